[rtl/core/tat_pkg.sv]
// Shared types, constants and handle helpers for the thread alias table.
// No dependencies; used by tat_mem, tat_cmp and thread_alias_table.
`default_nettype none

package tat_pkg;

  localparam int unsigned SLOTS = 32;
  localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  localparam logic [15:0] HANDLE_BASE = 16'hffe0;
  localparam int unsigned HANDLE_SHIFT = 3;  // handle step of 8

  typedef enum logic [1:0] {
    KIND_ADD    = 2'd0,
    KIND_FIND   = 2'd1,
    KIND_REMOVE = 2'd2,
    KIND_GET    = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    CMP_EQ_THREAD,
    CMP_LT_CREATED,
    CMP_EQ_LIVE
  } cmp_op_e;

  typedef struct packed {
    logic [31:0] thread;
    logic [31:0] process;
    logic [63:0] created;
  } row_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    row_t             wdata;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic             ok;
    logic [IDX_W-1:0] slot;
  } slot_ref_t;

  function automatic logic [15:0] slot_to_handle(logic [IDX_W-1:0] s);
    logic [15:0] off;
    off = 16'(s) << HANDLE_SHIFT;
    return HANDLE_BASE - off;
  endfunction

  function automatic slot_ref_t handle_to_slot(logic [15:0] h);
    logic [15:0] diff;
    logic [12:0] d;
    slot_ref_t   r;
    diff   = HANDLE_BASE - h;
    d      = diff[15:HANDLE_SHIFT];
    r.ok   = (h != 16'd0) && (h <= HANDLE_BASE) && (h[HANDLE_SHIFT-1:0] == '0)
             && (d < 13'(SLOTS));
    r.slot = d[IDX_W-1:0];
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/core/tat_mem.sv]
// Slot storage: one write port, one read port with registered read data.
// Depends on tat_pkg for the row layout and the request struct.
`default_nettype none

module tat_mem (
  input  wire logic              clk_i,
  input  wire tat_pkg::mem_req_t req_i,
  output tat_pkg::row_t          rdata_o
);

  tat_pkg::row_t mem_q [tat_pkg::SLOTS];
  tat_pkg::row_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem_q[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/core/tat_cmp.sv]
// Shared compare unit: thread match, creation-time order, live-info match.
// Depends on tat_pkg for the row layout and the compare codes.
`default_nettype none

module tat_cmp (
  input  wire tat_pkg::cmp_op_e op_i,
  input  wire tat_pkg::row_t    row_i,
  input  wire tat_pkg::row_t    key_i,
  output logic                  hit_o
);

  always_comb begin
    case (op_i)
      tat_pkg::CMP_EQ_THREAD:  hit_o = (row_i.thread == key_i.thread);
      tat_pkg::CMP_LT_CREATED: hit_o = (row_i.created < key_i.created);
      tat_pkg::CMP_EQ_LIVE:    hit_o = (row_i.process == key_i.process) &&
                                       (row_i.created == key_i.created);
      default:                 hit_o = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

[rtl/core/thread_alias_table.sv]
// Thread alias table top level: request sequencer and occupancy bits.
// Depends on tat_pkg, tat_mem and tat_cmp.
//
// A request transfers at a rising edge with start high and busy low; busy
// then stays high until the result, which sits on the result ports for the
// single cycle that done_o is high. The receiver cannot stall, so capture the
// result in that cycle. A new request may transfer in the strobe cycle.
// Remove and rejected requests strobe straight from idle; get passes through
// S_GET_RD, then S_GET_CHK. Add and find walk the slots one per cycle through
// the single read port of the slot store, checking each row in the shared
// compare unit; find stops at the first match from the top slot, add at the
// first empty slot, or on a full table at the last, overwriting the oldest.
// Occupancy lives in one flip-flop per slot, cleared at reset, so the store
// needs no clearing pass and is usable right after reset.
`default_nettype none

module thread_alias_table (
  input  wire  logic        clk_i,
  input  wire  logic        rst_ni,
  input  wire  logic        start,
  output logic              busy,
  input  wire  logic [1:0]  kind_i,
  input  wire  logic [31:0] thread_id_i,
  input  wire  logic [15:0] handle_i,
  input  wire  logic        thread_ok_i,
  input  wire  logic [31:0] live_process_id_i,
  input  wire  logic [63:0] live_created_i,
  output logic              done_o,
  output logic [15:0]       alias_handle_o,
  output logic [31:0]       found_thread_o,
  output logic [31:0]       found_process_o,
  output logic [5:0]        used_slots_o
);

  localparam int unsigned IW = tat_pkg::IDX_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_GET_RD,
    S_GET_CHK
  } state_e;

  state_e                  state_q;
  tat_pkg::kind_e          kind_q;
  logic [31:0]             tid_q;
  logic                    ok_q;
  logic [31:0]             lpid_q;
  logic [63:0]             lcre_q;
  logic [IW-1:0]           slot_q;     // decoded handle slot for get
  logic [IW-1:0]           idx_q;      // next slot to read
  logic                    stop_q;     // all reads of the walk issued
  logic                    chk_vld_q;  // read data valid for chk_idx_q
  logic [IW-1:0]           chk_idx_q;
  logic [63:0]             oldest_q;
  logic [IW-1:0]           use_q;
  logic [tat_pkg::SLOTS-1:0] valid_q;
  logic [5:0]              count_q;
  logic                    done_q;
  logic [15:0]             res_handle_q;
  logic [31:0]             res_thread_q;
  logic [31:0]             res_proc_q;

  tat_pkg::mem_req_t mem_req;
  tat_pkg::row_t     rdata;
  tat_pkg::row_t     cmp_key;
  tat_pkg::cmp_op_e  cmp_op;
  logic              cmp_hit;
  tat_pkg::slot_ref_t in_ref;

  logic add_chk, find_chk, add_empty, add_last;

  assign busy   = (state_q != S_IDLE);
  assign in_ref = tat_pkg::handle_to_slot(handle_i);

  // Walk bookkeeping for the check cycle of an add or find.
  assign add_chk   = (state_q == S_SCAN) && chk_vld_q && (kind_q == tat_pkg::KIND_ADD);
  assign find_chk  = (state_q == S_SCAN) && chk_vld_q && (kind_q == tat_pkg::KIND_FIND);
  assign add_empty = !valid_q[chk_idx_q];
  assign add_last  = (chk_idx_q == tat_pkg::LAST_IDX);

  // Steer the shared compare unit.
  always_comb begin
    cmp_key.thread  = tid_q;
    cmp_key.process = lpid_q;
    cmp_key.created = lcre_q;
    cmp_op          = tat_pkg::CMP_EQ_LIVE;
    if (state_q == S_SCAN) begin
      if (kind_q == tat_pkg::KIND_ADD) begin
        cmp_op          = tat_pkg::CMP_LT_CREATED;
        cmp_key.created = oldest_q;
      end else begin
        cmp_op = tat_pkg::CMP_EQ_THREAD;
      end
    end
  end

  // Store port: read the walk index or the get slot; write on the add check
  // that lands on an empty slot or closes a full-table walk.
  always_comb begin
    mem_req.raddr         = (state_q == S_SCAN) ? idx_q : slot_q;
    mem_req.we            = add_chk && (add_empty || add_last);
    mem_req.waddr         = (add_empty || cmp_hit) ? chk_idx_q : use_q;
    mem_req.wdata.thread  = tid_q;
    mem_req.wdata.process = lpid_q;
    mem_req.wdata.created = lcre_q;
  end

  tat_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

  tat_cmp u_cmp (
    .op_i  (cmp_op),
    .row_i (rdata),
    .key_i (cmp_key),
    .hit_o (cmp_hit)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      kind_q       <= tat_pkg::KIND_ADD;
      tid_q        <= '0;
      ok_q         <= 1'b0;
      lpid_q       <= '0;
      lcre_q       <= '0;
      slot_q       <= '0;
      idx_q        <= '0;
      stop_q       <= 1'b0;
      chk_vld_q    <= 1'b0;
      chk_idx_q    <= '0;
      oldest_q     <= '0;
      use_q        <= '0;
      valid_q      <= '0;
      count_q      <= '0;
      done_q       <= 1'b0;
      res_handle_q <= '0;
      res_thread_q <= '0;
      res_proc_q   <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (start) begin
            kind_q       <= tat_pkg::kind_e'(kind_i);
            tid_q        <= thread_id_i;
            ok_q         <= thread_ok_i;
            lpid_q       <= live_process_id_i;
            lcre_q       <= live_created_i;
            slot_q       <= in_ref.slot;
            res_handle_q <= '0;
            res_thread_q <= '0;
            res_proc_q   <= '0;
            stop_q       <= 1'b0;
            chk_vld_q    <= 1'b0;
            oldest_q     <= '1;
            use_q        <= '0;
            case (tat_pkg::kind_e'(kind_i))
              tat_pkg::KIND_ADD: begin
                idx_q <= '0;
                if (thread_ok_i && (thread_id_i != 32'd0)) begin
                  state_q <= S_SCAN;
                end else begin
                  done_q <= 1'b1;
                end
              end
              tat_pkg::KIND_FIND: begin
                idx_q <= tat_pkg::LAST_IDX;
                if (thread_id_i != 32'd0) begin
                  state_q <= S_SCAN;
                end else begin
                  done_q <= 1'b1;
                end
              end
              tat_pkg::KIND_REMOVE: begin
                // Drop an occupied slot; ignore bad handles and empty slots.
                if (in_ref.ok && valid_q[in_ref.slot]) begin
                  valid_q[in_ref.slot] <= 1'b0;
                  count_q              <= count_q - 6'd1;
                end
                done_q <= 1'b1;
              end
              tat_pkg::KIND_GET: begin
                if (in_ref.ok && valid_q[in_ref.slot]) begin
                  state_q <= S_GET_RD;
                end else begin
                  done_q <= 1'b1;
                end
              end
              default: begin
                done_q <= 1'b1;
              end
            endcase
          end
        end

        S_SCAN: begin
          // Issue one read per cycle; add walks up, find walks down.
          if (!stop_q) begin
            if (kind_q == tat_pkg::KIND_ADD) begin
              if (idx_q == tat_pkg::LAST_IDX) begin
                stop_q <= 1'b1;
              end else begin
                idx_q <= idx_q + IW'(1);
              end
            end else begin
              if (idx_q == '0) begin
                stop_q <= 1'b1;
              end else begin
                idx_q <= idx_q - IW'(1);
              end
            end
          end
          chk_vld_q <= !stop_q;
          chk_idx_q <= idx_q;

          if (add_chk) begin
            if (add_empty) begin
              // Take the lowest empty slot.
              valid_q[chk_idx_q] <= 1'b1;
              count_q            <= count_q + 6'd1;
              res_handle_q       <= tat_pkg::slot_to_handle(chk_idx_q);
              done_q             <= 1'b1;
              state_q            <= S_IDLE;
            end else if (add_last) begin
              // Table full: overwrite the oldest slot, count unchanged.
              res_handle_q <= tat_pkg::slot_to_handle(mem_req.waddr);
              done_q       <= 1'b1;
              state_q      <= S_IDLE;
            end else if (cmp_hit) begin
              oldest_q <= rdata.created;
              use_q    <= chk_idx_q;
            end
          end

          if (find_chk) begin
            if (valid_q[chk_idx_q] && cmp_hit) begin
              res_handle_q <= tat_pkg::slot_to_handle(chk_idx_q);
              done_q       <= 1'b1;
              state_q      <= S_IDLE;
            end else if (chk_idx_q == '0) begin
              done_q  <= 1'b1;
              state_q <= S_IDLE;
            end
          end
        end

        S_GET_RD: begin
          state_q <= S_GET_CHK;
        end

        S_GET_CHK: begin
          // Return the stored ids on a live match, else drop the slot.
          if (ok_q && cmp_hit) begin
            res_thread_q <= rdata.thread;
            res_proc_q   <= rdata.process;
          end else begin
            valid_q[slot_q] <= 1'b0;
            count_q         <= count_q - 6'd1;
          end
          done_q  <= 1'b1;
          state_q <= S_IDLE;
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign done_o          = done_q;
  assign alias_handle_o  = res_handle_q;
  assign found_thread_o  = res_thread_q;
  assign found_process_o = res_proc_q;
  assign used_slots_o    = count_q;

endmodule

`default_nettype wire

[tb/thread_alias_table_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for thread_alias_table: directed and random requests.
// Depends on tat_pkg for the request kinds, slot count and handle base.

typedef struct packed {
  logic [15:0] handle;
  logic [31:0] thread;
  logic [31:0] process;
  logic [5:0]  used;
} alias_reply_t;

// Shadow copy of the alias table; predicts the reply of each request.
class alias_shadow;
  logic [31:0]  slot_tid  [tat_pkg::SLOTS];
  logic [31:0]  slot_pid  [tat_pkg::SLOTS];
  logic [63:0]  slot_born [tat_pkg::SLOTS];
  int unsigned  occupied;
  alias_reply_t replies_due[$];
  int unsigned  errors;

  function new();
    for (int s = 0; s < tat_pkg::SLOTS; s++) begin
      slot_tid[s]  = '0;
      slot_pid[s]  = '0;
      slot_born[s] = '0;
    end
    occupied = 0;
    errors   = 0;
  endfunction

  function logic [15:0] handle_of(int s);
    return tat_pkg::HANDLE_BASE - 16'(s * 8);
  endfunction

  // Slot named by a handle, or -1 when the handle names none.
  function int slot_of(logic [15:0] h);
    logic [15:0] d;
    d = tat_pkg::HANDLE_BASE - h;
    if (h == 16'd0 || h > tat_pkg::HANDLE_BASE || d[2:0] != 3'd0) return -1;
    if (int'(d >> 3) >= tat_pkg::SLOTS) return -1;
    return int'(d >> 3);
  endfunction

  function void vacate(int s);
    if (slot_tid[s] != 32'd0) begin
      slot_tid[s]  = '0;
      slot_pid[s]  = '0;
      slot_born[s] = '0;
      if (occupied > 0) occupied--;
    end
  endfunction

  function void apply_request(tat_pkg::kind_e k, logic [31:0] tid, logic [15:0] hnd,
                              logic ok, logic [31:0] lpid, logic [63:0] lcre);
    alias_reply_t r;
    int           victim;
    int           s;
    logic [63:0]  oldest;
    r = '0;
    case (k)
      tat_pkg::KIND_ADD: begin
        if (ok && tid != 32'd0) begin
          victim = -1;
          for (s = 0; s < tat_pkg::SLOTS; s++)
            if (victim < 0 && slot_tid[s] == 32'd0) victim = s;
          if (victim >= 0) begin
            occupied++;
          end else begin
            // full: strictly oldest wins, lowest index on ties
            victim = 0;
            oldest = '1;
            for (s = 0; s < tat_pkg::SLOTS; s++)
              if (slot_born[s] < oldest) begin
                oldest = slot_born[s];
                victim = s;
              end
          end
          slot_tid[victim]  = tid;
          slot_pid[victim]  = lpid;
          slot_born[victim] = lcre;
          r.handle = handle_of(victim);
        end
      end
      tat_pkg::KIND_FIND: begin
        if (tid != 32'd0)
          for (s = tat_pkg::SLOTS - 1; s >= 0; s--)
            if (r.handle == 16'd0 && slot_tid[s] == tid) r.handle = handle_of(s);
      end
      tat_pkg::KIND_REMOVE: begin
        s = slot_of(hnd);
        if (s >= 0) vacate(s);
      end
      default: begin
        s = slot_of(hnd);
        if (s >= 0 && slot_tid[s] != 32'd0) begin
          if (ok && slot_born[s] == lcre && slot_pid[s] == lpid) begin
            r.thread  = slot_tid[s];
            r.process = slot_pid[s];
          end else begin
            vacate(s);
          end
        end
      end
    endcase
    r.used = 6'(occupied);
    replies_due.push_back(r);
  endfunction

  function void check_reply(logic [15:0] h, logic [31:0] thr, logic [31:0] prc,
                            logic [5:0] used);
    alias_reply_t e;
    if (replies_due.size() == 0) begin
      $error("result with no request outstanding: alias_handle %h", h);
      errors++;
    end else begin
      e = replies_due.pop_front();
      if (h !== e.handle) begin
        $error("alias_handle: expected %h, got %h", e.handle, h);
        errors++;
      end
      if (thr !== e.thread) begin
        $error("found_thread: expected %h, got %h", e.thread, thr);
        errors++;
      end
      if (prc !== e.process) begin
        $error("found_process: expected %h, got %h", e.process, prc);
        errors++;
      end
      if (used !== e.used) begin
        $error("used_slots: expected %0d, got %0d", e.used, used);
        errors++;
      end
    end
  endfunction
endclass

module thread_alias_table_tb;

  // Cycle limit for the run, set well above what the slowest run needs.
  localparam int unsigned CYCLE_LIMIT = 300000;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [1:0]  kind_i;
  logic [31:0] thread_id_i;
  logic [15:0] handle_i;
  logic        thread_ok_i;
  logic [31:0] live_process_id_i;
  logic [63:0] live_created_i;
  logic        done_o;
  logic [15:0] alias_handle_o;
  logic [31:0] found_thread_o;
  logic [31:0] found_process_o;
  logic [5:0]  used_slots_o;

  alias_shadow sb = new();
  int unsigned cycle_count = 0;
  int          idle_pct;

  thread_alias_table u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .kind_i            (kind_i),
    .thread_id_i       (thread_id_i),
    .handle_i          (handle_i),
    .thread_ok_i       (thread_ok_i),
    .live_process_id_i (live_process_id_i),
    .live_created_i    (live_created_i),
    .done_o            (done_o),
    .alias_handle_o    (alias_handle_o),
    .found_thread_o    (found_thread_o),
    .found_process_o   (found_process_o),
    .used_slots_o      (used_slots_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Hard stop in case a transfer or a result never arrives.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // The receiver cannot stall: check every strobed result at the edge that ends it.
  always @(posedge clk_i) begin
    if (rst_ni && done_o)
      sb.check_reply(alias_handle_o, found_thread_o, found_process_o, used_slots_o);
  end

  // Issue one request. Enter and leave at a falling edge. Idle first at the
  // current rate, now and then for a long stretch so that the next start lands
  // on every cycle of an add or find scan; then hold start until the transfer.
  task automatic send(input tat_pkg::kind_e k, input logic [31:0] tid,
                      input logic [15:0] hnd, input logic ok, input logic [31:0] lpid,
                      input logic [63:0] lcre);
    int gap;
    gap = 0;
    if (idle_pct != 0 && $urandom_range(99) < 3) gap = $urandom_range(40, 1);
    else while ($urandom_range(99) < idle_pct) gap++;
    repeat (gap) begin
      // idle cycle: drop start, scramble the payload
      start             = 1'b0;
      kind_i            = 2'($urandom);
      thread_id_i       = $urandom;
      handle_i          = 16'($urandom);
      thread_ok_i       = 1'($urandom);
      live_process_id_i = $urandom;
      live_created_i    = {$urandom, $urandom};
      @(negedge clk_i);
    end
    start             = 1'b1;
    kind_i            = k;
    thread_id_i       = tid;
    handle_i          = hnd;
    thread_ok_i       = ok;
    live_process_id_i = lpid;
    live_created_i    = lcre;
    do @(posedge clk_i); while (busy);
    sb.apply_request(k, tid, hnd, ok, lpid, lcre);
    @(negedge clk_i);
  endtask

  // Mostly a small pool so that adds collide and finds hit; else any id.
  function automatic logic [31:0] pick_tid();
    if ($urandom_range(9) < 7) return 32'($urandom_range(48, 1));
    return $urandom;
  endfunction

  // Mostly valid handles; the rest zero, misaligned, beyond the top or random.
  function automatic logic [15:0] pick_handle();
    int r;
    r = $urandom_range(99);
    if (r < 75) return sb.handle_of($urandom_range(tat_pkg::SLOTS - 1));
    if (r < 80) return 16'd0;
    if (r < 85)
      return sb.handle_of($urandom_range(tat_pkg::SLOTS - 1)) + 16'($urandom_range(7, 1));
    if (r < 90) return sb.handle_of($urandom_range(tat_pkg::SLOTS + 8, tat_pkg::SLOTS));
    return 16'($urandom);
  endfunction

  task automatic random_request();
    logic [31:0] tid;
    logic [31:0] lpid;
    logic [15:0] hnd;
    logic        ok;
    logic [63:0] lcre;
    int          r;
    int          s;
    tid  = $urandom;
    hnd  = 16'($urandom);
    ok   = 1'($urandom);
    lpid = $urandom;
    lcre = {$urandom, $urandom};
    r    = $urandom_range(99);
    if (r < 40) begin
      tid = ($urandom_range(19) == 0) ? 32'd0 : pick_tid();
      ok  = ($urandom_range(15) != 0);
      // a small set of creation times forces ties in the oldest-slot choice
      if ($urandom_range(3) == 0) begin
        case ($urandom_range(3))
          0: lcre = 64'd0;
          1: lcre = 64'd1;
          2: lcre = 64'd2;
          default: lcre = '1;
        endcase
      end
      send(tat_pkg::KIND_ADD, tid, hnd, ok, lpid, lcre);
    end else if (r < 60) begin
      tid = ($urandom_range(9) == 0) ? 32'd0 : pick_tid();
      send(tat_pkg::KIND_FIND, tid, hnd, ok, lpid, lcre);
    end else if (r < 75) begin
      send(tat_pkg::KIND_REMOVE, tid, pick_handle(), ok, lpid, lcre);
    end else begin
      hnd = pick_handle();
      s   = sb.slot_of(hnd);
      ok  = ($urandom_range(7) != 0);
      // usually present the live info that is stored, sometimes one bit off
      if (s >= 0 && $urandom_range(3) != 0) begin
        lpid = sb.slot_pid[s];
        lcre = sb.slot_born[s];
        if ($urandom_range(7) == 0) lcre ^= 64'd1 << $urandom_range(63);
      end
      send(tat_pkg::KIND_GET, tid, hnd, ok, lpid, lcre);
    end
  endtask

  initial begin
    int phase;
    int s;
    rst_ni            = 1'b0;
    start             = 1'b0;
    kind_i            = '0;
    thread_id_i       = '0;
    handle_i          = '0;
    thread_ok_i       = 1'b0;
    live_process_id_i = '0;
    live_created_i    = '0;
    idle_pct          = 25;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Requests on an empty table, zero ids and a failed live query.
    send(tat_pkg::KIND_GET,    32'd0, 16'hffe0, 1'b1, 32'd0, 64'd0);
    send(tat_pkg::KIND_REMOVE, 32'd0, 16'hffe0, 1'b0, 32'd0, 64'd0);
    send(tat_pkg::KIND_FIND,   32'd0, 16'd0, 1'b0, 32'd0, 64'd0);
    send(tat_pkg::KIND_FIND,   '1, 16'd0, 1'b0, 32'd0, 64'd0);
    send(tat_pkg::KIND_ADD,    32'd5, 16'd0, 1'b0, 32'd1, 64'd1);
    send(tat_pkg::KIND_ADD,    32'd0, 16'd0, 1'b1, 32'd1, 64'd1);
    // All-ones entry in slot 0, then find it and read it back.
    send(tat_pkg::KIND_ADD,    '1, 16'd0, 1'b1, '1, '1);
    send(tat_pkg::KIND_FIND,   '1, 16'hffff, 1'b1, '1, '1);
    send(tat_pkg::KIND_GET,    32'd0, 16'hffe0, 1'b1, '1, '1);
    // Handles that name no slot: zero, misaligned, above the base; then an empty slot.
    send(tat_pkg::KIND_GET,    32'd0, 16'd0, 1'b1, '1, '1);
    send(tat_pkg::KIND_GET,    32'd0, 16'hffe1, 1'b1, '1, '1);
    send(tat_pkg::KIND_REMOVE, 32'd0, 16'hffff, 1'b1, '1, '1);
    send(tat_pkg::KIND_GET,    32'd0, 16'hff00, 1'b1, '1, '1);
    // Get with the live query failed clears the slot; so does a stale process id.
    send(tat_pkg::KIND_GET,    32'd0, 16'hffe0, 1'b0, '1, '1);
    send(tat_pkg::KIND_ADD,    32'd1, 16'd0, 1'b1, 32'd0, 64'd0);
    send(tat_pkg::KIND_GET,    32'd0, 16'hffe0, 1'b1, 32'd1, 64'd0);

    // Fill every slot with the maximum creation time; the next add lands in slot 0.
    for (s = 0; s < tat_pkg::SLOTS; s++)
      send(tat_pkg::KIND_ADD, 32'h100 + 32'(s), 16'd0, 1'b1, $urandom, '1);
    send(tat_pkg::KIND_ADD,    32'h00ab_cdef, 16'd0, 1'b1, $urandom, 64'd5);
    send(tat_pkg::KIND_ADD,    32'h00ab_cdf0, 16'd0, 1'b1, $urandom, 64'd0);
    // Last slot: read, drop, look up, and refill through the lowest empty slot.
    send(tat_pkg::KIND_GET,    32'd0, sb.handle_of(tat_pkg::SLOTS - 1), 1'b1,
         sb.slot_pid[tat_pkg::SLOTS - 1], '1);
    send(tat_pkg::KIND_REMOVE, 32'd0, sb.handle_of(tat_pkg::SLOTS - 1), 1'b0, 32'd0, 64'd0);
    send(tat_pkg::KIND_FIND,   32'h100 + 32'(tat_pkg::SLOTS - 1), 16'd0, 1'b0, 32'd0, 64'd0);
    send(tat_pkg::KIND_FIND,   32'h100 + 32'(tat_pkg::SLOTS - 2), 16'd0, 1'b0, 32'd0, 64'd0);
    send(tat_pkg::KIND_ADD,    32'h0000_0777, 16'd0, 1'b1, $urandom, {$urandom, $urandom});

    // Random phases; each starts by emptying the table so occupancy sweeps its range.
    for (phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 25 : (phase == 1) ? 60 : 0;
      for (s = 0; s < tat_pkg::SLOTS; s++)
        send(tat_pkg::KIND_REMOVE, $urandom, sb.handle_of(s), 1'($urandom), $urandom,
             {$urandom, $urandom});
      repeat (135) random_request();
    end

    // Drain: wait out outstanding results, then a scan's worth of quiet cycles.
    start = 1'b0;
    while (sb.replies_due.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (sb.errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
